>>> design/ffba_pkg.sv
`timescale 1ns / 1ps
package ffba_pkg;

  localparam int unsigned StoreWords = 16384;
  localparam int unsigned AddrW = 14;
  localparam int unsigned SizeW = 17;
  localparam logic [SizeW-1:0] HeaderBytes = 17'd16;

  typedef struct packed {
    logic [16:0] size;
    logic [13:0] next;
    logic [13:0] prev;
    logic        has_next;
    logic        has_prev;
    logic        busy;
  } hdr_t;

  typedef struct packed {
    logic        op;
    logic [16:0] req_bytes;
    logic [15:0] handle;
  } req_t;

  typedef struct packed {
    logic [15:0] address;
    logic        ok;
  } rsp_t;

  localparam logic OpAlloc = 1'b0;
  localparam logic OpFree  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_A_RD,
    ST_A_CHK,
    ST_A_SPLIT_RD,
    ST_A_SPLIT_FIX,
    ST_F_RD,
    ST_F_CUR,
    ST_F_PREV,
    ST_F_PREV_NEXT,
    ST_F_NEXT,
    ST_F_NEXT_NEXT,
    ST_DONE
  } state_t;

endpackage

>>> design/ffba_hdr_ram.sv
`timescale 1ns / 1ps
module ffba_hdr_ram (
  input  logic                          clk,
  input  logic                          we,
  input  logic [ffba_pkg::AddrW-1:0]    waddr,
  input  ffba_pkg::hdr_t                wdata,
  input  logic [ffba_pkg::AddrW-1:0]    raddr,
  output ffba_pkg::hdr_t                rdata
);

  ffba_pkg::hdr_t mem [ffba_pkg::StoreWords];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/first_fit_block_allocator_unit.sv
`timescale 1ns / 1ps
// First-fit allocator over a pool of up to 64 KiB kept as a linked chain of 16-byte
// headers in a single-port-write, registered-read header RAM. One transaction
// at a time: busy is high from the accepting edge until the result strobe,
// which comes in the first cycle that busy is low. An allocate holds busy
// while it walks the header chain and, when the block is split, while it
// writes the split headers; a free holds busy while it reads and merges the
// neighbouring headers. The RAM read/modify/write sequence sets these busy
// times. The result is shown for one cycle with done and cannot be stalled.
// After reset and after each pool_size write the block writes the first
// header before taking a transaction.
module first_fit_block_allocator_unit (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  ffba_pkg::req_t   req,
  output logic             done,
  output ffba_pkg::rsp_t   rsp,
  input  logic             cfg_we,
  input  logic [16:0]      cfg_data
);

  localparam int unsigned AW = ffba_pkg::AddrW;

  ffba_pkg::state_t state, state_next;
  logic [16:0]   pool_size;
  ffba_pkg::req_t cur_req;
  logic [AW-1:0] cur, cur_next;
  logic [AW-1:0] aux, aux_next;
  ffba_pkg::hdr_t h, h_next;
  logic [17:0]   need;
  logic [AW:0]   visits, visits_next;
  ffba_pkg::rsp_t rsp_next;
  logic          done_next;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  ffba_pkg::hdr_t wdata, rdata;
  logic [16:0]   bytes;
  logic [16:0]   rem;
  ffba_pkg::hdr_t split_hdr;

  ffba_hdr_ram u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  always_comb begin
    bytes = pool_size;
    if (bytes < 17'd32) bytes = 17'd32;
    if (bytes > 17'd65536) bytes = 17'd65536;
    bytes = bytes & ~17'd3;
  end

  assign rem = h.size - need[16:0];
  assign split_hdr = '{size: rem, next: h.next, prev: cur, has_next: h.has_next,
                       has_prev: 1'b1, busy: 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ffba_pkg::ST_INIT;
      pool_size <= 17'd65536;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= done_next;
      if (cfg_we) begin
        pool_size <= cfg_data;
        state <= ffba_pkg::ST_INIT;
      end
    end
    cur <= cur_next;
    aux <= aux_next;
    h <= h_next;
    visits <= visits_next;
    rsp <= rsp_next;
    if (start && !busy) begin
      cur_req <= req;
      need <= ((18'(req.req_bytes) + 18'd3) & ~18'd3) + 18'(ffba_pkg::HeaderBytes);
    end
  end

  assign busy = (state != ffba_pkg::ST_IDLE);

  always_comb begin
    state_next = state;
    cur_next = cur;
    aux_next = aux;
    h_next = h;
    visits_next = visits;
    rsp_next = rsp;
    done_next = 1'b0;
    we = 1'b0;
    waddr = cur;
    wdata = h;
    raddr = cur;
    unique case (state)
      ffba_pkg::ST_IDLE: begin
        if (start) begin
          if (req.op == ffba_pkg::OpAlloc) begin
            cur_next = '0;
            visits_next = '0;
            raddr = '0;
            state_next = ffba_pkg::ST_A_CHK;
          end else begin
            cur_next = AW'((req.handle - 16'd16) >> 2);
            raddr = AW'((req.handle - 16'd16) >> 2);
            state_next = ffba_pkg::ST_F_CUR;
          end
        end
      end
      ffba_pkg::ST_INIT: begin
        we = 1'b1;
        waddr = '0;
        wdata = '{size: bytes, next: '0, prev: '0, has_next: 1'b0,
                  has_prev: 1'b0, busy: 1'b0};
        state_next = ffba_pkg::ST_IDLE;
      end
      ffba_pkg::ST_A_RD: begin
        raddr = cur;
        state_next = ffba_pkg::ST_A_CHK;
      end
      ffba_pkg::ST_A_CHK: begin
        h_next = rdata;
        if (!rdata.busy && 18'(rdata.size) >= need) begin
          if (rdata.size - need[16:0] > ffba_pkg::HeaderBytes) begin
            aux_next = cur + AW'(need >> 2);
            state_next = ffba_pkg::ST_A_SPLIT_RD;
          end else begin
            we = 1'b1;
            wdata = rdata;
            wdata.busy = 1'b1;
            rsp_next = '{address: {cur, 2'b00} + 16'd16, ok: 1'b1};
            done_next = 1'b1;
            state_next = ffba_pkg::ST_IDLE;
          end
        end else if (!rdata.has_next || (visits + 1'b1) >= (AW+1)'(ffba_pkg::StoreWords)) begin
          rsp_next = '{address: '0, ok: 1'b0};
          done_next = 1'b1;
          state_next = ffba_pkg::ST_IDLE;
        end else begin
          visits_next = visits + 1'b1;
          cur_next = rdata.next;
          state_next = ffba_pkg::ST_A_RD;
        end
      end
      ffba_pkg::ST_A_SPLIT_RD: begin
        // write remainder header, then fix next's prev link
        we = 1'b1;
        waddr = aux;
        wdata = split_hdr;
        if (aux == cur) begin
          h_next.prev = cur;
          h_next.has_prev = 1'b1;
        end
        raddr = h.next;
        state_next = ffba_pkg::ST_A_SPLIT_FIX;
      end
      ffba_pkg::ST_A_SPLIT_FIX: begin
        if (h.has_next) begin
          we = 1'b1;
          waddr = h.next;
          wdata = (h.next == aux) ? split_hdr : rdata;
          wdata.prev = aux;
          if (h.next == cur) h_next.prev = aux;
          state_next = ffba_pkg::ST_F_RD;
        end else begin
          state_next = ffba_pkg::ST_F_RD;
        end
      end
      ffba_pkg::ST_F_RD: begin
        // finish allocate split: write shrunk busy current header
        we = 1'b1;
        waddr = cur;
        wdata = h;
        wdata.size = need[16:0];
        wdata.next = aux;
        wdata.has_next = 1'b1;
        wdata.busy = 1'b1;
        rsp_next = '{address: {cur, 2'b00} + 16'd16, ok: 1'b1};
        done_next = 1'b1;
        state_next = ffba_pkg::ST_IDLE;
      end
      ffba_pkg::ST_F_CUR: begin
        h_next = rdata;
        h_next.busy = 1'b0;
        we = 1'b1;
        wdata = rdata;
        wdata.busy = 1'b0;
        raddr = rdata.prev;
        aux_next = rdata.prev;
        if (rdata.has_prev && rdata.prev != cur) begin
          state_next = ffba_pkg::ST_F_PREV;
        end else begin
          raddr = rdata.next;
          aux_next = rdata.next;
          state_next = ffba_pkg::ST_F_NEXT;
        end
      end
      ffba_pkg::ST_F_PREV: begin
        if (!rdata.busy) begin
          h_next = rdata;
          h_next.size = rdata.size + h.size;
          h_next.next = h.next;
          h_next.has_next = h.has_next;
          we = 1'b1;
          waddr = aux;
          wdata = h_next;
          cur_next = aux;
          raddr = h.next;
          state_next = ffba_pkg::ST_F_PREV_NEXT;
        end else begin
          raddr = h.next;
          aux_next = h.next;
          state_next = ffba_pkg::ST_F_NEXT;
        end
      end
      ffba_pkg::ST_F_PREV_NEXT: begin
        if (h.has_next) begin
          we = 1'b1;
          waddr = h.next;
          wdata = (h.next == cur) ? h : rdata;
          wdata.prev = cur;
          if (h.next == cur) h_next.prev = cur;
        end
        aux_next = h.next;
        state_next = ffba_pkg::ST_F_NEXT_NEXT;
      end
      ffba_pkg::ST_F_NEXT_NEXT: begin
        // reissue read of next after possible write to it
        raddr = aux;
        state_next = ffba_pkg::ST_F_NEXT;
      end
      ffba_pkg::ST_F_NEXT: begin
        if (h.has_next && !rdata.busy && aux != cur) begin
          h_next = h;
          h_next.size = h.size + rdata.size;
          h_next.next = rdata.next;
          h_next.has_next = rdata.has_next;
          we = 1'b1;
          waddr = cur;
          wdata = h_next;
          raddr = rdata.next;
          aux_next = rdata.next;
          state_next = rdata.has_next ? ffba_pkg::ST_DONE : ffba_pkg::ST_IDLE;
          done_next = !rdata.has_next;
          rsp_next = '{address: '0, ok: 1'b1};
        end else begin
          rsp_next = '{address: '0, ok: 1'b1};
          done_next = 1'b1;
          state_next = ffba_pkg::ST_IDLE;
        end
      end
      ffba_pkg::ST_DONE: begin
        we = 1'b1;
        waddr = aux;
        wdata = (aux == cur) ? h : rdata;
        wdata.prev = cur;
        rsp_next = '{address: '0, ok: 1'b1};
        done_next = 1'b1;
        state_next = ffba_pkg::ST_IDLE;
      end
      default: state_next = ffba_pkg::ST_IDLE;
    endcase
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == ffba_pkg::ST_IDLE) else $error("done outside idle");
  a_free_ok: assert property (@(posedge clk) disable iff (rst)
    done && cur_req.op == ffba_pkg::OpFree |-> rsp.ok && rsp.address == 16'd0)
    else $error("free result wrong");
  a_fail_addr: assert property (@(posedge clk) disable iff (rst)
    done && !rsp.ok |-> rsp.address == 16'd0) else $error("fail address nonzero");

endmodule

>>> tb/sv/first_fit_block_allocator_unit_checker.sv
`timescale 1ns / 1ps
module first_fit_block_allocator_unit_checker (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            busy,
  input  ffba_pkg::req_t  req,
  input  logic            done,
  input  ffba_pkg::rsp_t  rsp,
  input  logic            cfg_we,
  input  logic [16:0]     cfg_data,
  output int              mismatches,
  output int              outstanding
);

  logic [16:0] blk_size [ffba_pkg::StoreWords];
  logic [13:0] blk_next [ffba_pkg::StoreWords];
  logic [13:0] blk_prev [ffba_pkg::StoreWords];
  bit          blk_has_next [ffba_pkg::StoreWords];
  bit          blk_has_prev [ffba_pkg::StoreWords];
  bit          blk_busy [ffba_pkg::StoreWords];

  ffba_pkg::rsp_t expected_rsp[$];

  assign outstanding = expected_rsp.size();

  task automatic report(input string what, input int got, input int want);
    $display("%0t: mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic void init_pool(input logic [16:0] bytes_in);
    int unsigned bytes;
    bytes = bytes_in;
    if (bytes > 65536) bytes = 65536;
    if (bytes < 32) bytes = 32;
    bytes = bytes & ~32'd3;
    blk_size[0] = bytes[16:0];
    blk_next[0] = '0;
    blk_prev[0] = '0;
    blk_has_next[0] = 0;
    blk_has_prev[0] = 0;
    blk_busy[0] = 0;
  endfunction

  function automatic ffba_pkg::rsp_t alloc_block(input logic [16:0] req_bytes);
    int unsigned need, visits;
    logic [13:0] cur, rem;
    ffba_pkg::rsp_t r;
    need = ((req_bytes + 3) & ~32'd3) + 16;
    visits = 0;
    cur = '0;
    r = '0;
    forever begin
      if (!blk_busy[cur] && blk_size[cur] >= need) break;
      visits++;
      if (!blk_has_next[cur] || visits >= ffba_pkg::StoreWords) return r;
      cur = blk_next[cur];
    end
    if (blk_size[cur] - need > 16) begin
      rem = cur + 14'(need / 4);
      blk_size[rem] = 17'(blk_size[cur] - need);
      blk_next[rem] = blk_next[cur];
      blk_has_next[rem] = blk_has_next[cur];
      blk_prev[rem] = cur;
      blk_has_prev[rem] = 1;
      blk_busy[rem] = 0;
      if (blk_has_next[rem]) blk_prev[blk_next[rem]] = rem;
      blk_size[cur] = 17'(need);
      blk_next[cur] = rem;
      blk_has_next[cur] = 1;
    end
    blk_busy[cur] = 1;
    r.address = 16'({cur, 2'b00} + 16);
    r.ok = 1'b1;
    return r;
  endfunction

  function automatic void free_block(input logic [15:0] handle);
    logic [15:0] off;
    logic [13:0] cur, p, n;
    off = handle - 16'd16;
    cur = off[15:2];
    blk_busy[cur] = 0;
    if (blk_has_prev[cur]) begin
      p = blk_prev[cur];
      if (!blk_busy[p] && p != cur) begin
        blk_size[p] = blk_size[p] + blk_size[cur];
        blk_next[p] = blk_next[cur];
        blk_has_next[p] = blk_has_next[cur];
        if (blk_has_next[cur]) blk_prev[blk_next[cur]] = p;
        cur = p;
      end
    end
    if (blk_has_next[cur]) begin
      n = blk_next[cur];
      if (!blk_busy[n] && n != cur) begin
        blk_size[cur] = blk_size[cur] + blk_size[n];
        blk_next[cur] = blk_next[n];
        blk_has_next[cur] = blk_has_next[n];
        if (blk_has_next[n]) blk_prev[blk_next[n]] = cur;
      end
    end
  endfunction

  always @(posedge clk) begin
    ffba_pkg::rsp_t want;
    if (rst) begin
      for (int i = 0; i < ffba_pkg::StoreWords; i++) begin
        blk_size[i] = '0;
        blk_next[i] = '0;
        blk_prev[i] = '0;
        blk_has_next[i] = 0;
        blk_has_prev[i] = 0;
        blk_busy[i] = 0;
      end
      init_pool(17'h10000);
      expected_rsp.delete();
      mismatches = 0;
    end else begin
      if (cfg_we) init_pool(cfg_data);
      if (done) begin
        if (expected_rsp.size() == 0) begin
          report("unexpected transaction", rsp, 0);
        end else begin
          want = expected_rsp.pop_front();
          if (rsp.address !== want.address) report("address", rsp.address, want.address);
          if (rsp.ok !== want.ok) report("ok", rsp.ok, want.ok);
        end
      end
      if (start && !busy) begin
        if (req.op == ffba_pkg::OpAlloc) begin
          want = alloc_block(req.req_bytes);
        end else begin
          free_block(req.handle);
          want = '0;
          want.ok = 1'b1;
        end
        expected_rsp.push_back(want);
      end
    end
  end
endmodule

>>> tb/sv/first_fit_block_allocator_unit_test.sv
`timescale 1ns / 1ps
module first_fit_block_allocator_unit_test;

  localparam int StallLimit = 200000;

  logic           clk = 0;
  logic           rst = 1;
  logic           start = 0;
  logic           busy;
  ffba_pkg::req_t req = '0;
  logic           done;
  ffba_pkg::rsp_t rsp;
  logic           cfg_we = 0;
  logic [16:0]    cfg_data = '0;
  int             mismatches, outstanding;
  int             stall_cycles = 0;
  int             n_alloc = 0, n_free = 0, n_fail = 0, n_cfg = 0;
  bit             no_gaps = 0;
  logic [15:0]    live_handles[$];
  logic [15:0]    seen_handles[$];

  always #2 clk = ~clk;

  first_fit_block_allocator_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .done(done), .rsp(rsp), .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  first_fit_block_allocator_unit_checker chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .done(done), .rsp(rsp), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || cfg_we) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("first_fit_block_allocator_unit_test: errors");
        $finish;
      end
    end
  end

  task automatic run_transaction(input logic op, input logic [16:0] bytes_req,
                                 input logic [15:0] handle);
    while (!no_gaps && $urandom_range(0, 99) < 32) @(posedge clk);
    req <= '{op: op, req_bytes: bytes_req, handle: handle};
    start <= 1'b1;
    do @(posedge clk); while (busy);
    start <= 1'b0;
    req <= '{op: ~op, req_bytes: 17'($urandom), handle: 16'($urandom)};
    do @(posedge clk); while (!done);
    if (op == ffba_pkg::OpAlloc) begin
      n_alloc++;
      if (rsp.ok) begin
        live_handles.push_back(rsp.address);
        seen_handles.push_back(rsp.address);
      end else begin
        n_fail++;
      end
    end else begin
      n_free++;
    end
  endtask

  task automatic alloc(input logic [16:0] bytes_req);
    run_transaction(ffba_pkg::OpAlloc, bytes_req, 16'($urandom));
  endtask

  task automatic free_live(input int idx);
    logic [15:0] h;
    h = live_handles[idx];
    live_handles.delete(idx);
    run_transaction(ffba_pkg::OpFree, 17'($urandom), h);
  endtask

  task automatic set_pool(input logic [16:0] bytes);
    wait (outstanding == 0);
    repeat (16) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= bytes;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_data <= 17'($urandom);
    live_handles.delete();
    n_cfg++;
  endtask

  task automatic random_item();
    int pick;
    pick = $urandom_range(0, 99);
    if (live_handles.size() != 0 && pick < 45) begin
      free_live($urandom_range(0, live_handles.size() - 1));
    end else if (seen_handles.size() != 0 && pick < 48) begin
      // stale handle: header was written once, may be merged away since
      run_transaction(ffba_pkg::OpFree, 17'($urandom),
                      seen_handles[$urandom_range(0, seen_handles.size() - 1)]);
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 85) alloc(17'($urandom_range(0, 300)));
      else if (pick < 95) alloc(17'($urandom_range(0, 4096)));
      else alloc(17'($urandom));
    end
  endtask

  initial begin
    logic [16:0] pools[8];
    pools = '{17'd600, 17'd32, 17'h1ffff, 17'd0, 17'd4096, 17'd65536, 17'd1000, 17'd2048};
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // extremes and merge cases on the reset pool
    alloc(17'd0);
    alloc(17'd1);
    alloc(17'd5);
    alloc(17'd65536);
    alloc(17'h1ffff);
    free_live(0);
    free_live(0);
    free_live(0);
    alloc(17'd65520);
    alloc(17'd0);
    free_live(0);
    alloc(17'd65504);
    free_live(0);
    for (int i = 0; i < 5; i++) alloc(17'd4);
    free_live(1);
    free_live(2);
    free_live(1);
    run_transaction(ffba_pkg::OpFree, 17'h1ffff, 16'hffff - 16'hffef + 16'd16);
    free_live(0);
    free_live(0);

    // pause until the pipe drains
    wait (outstanding == 0);
    set_pool(17'd32);
    alloc(17'd0);
    alloc(17'd0);

    for (int ph = 0; ph < 8; ph++) begin
      set_pool(ph == 7 ? 17'($urandom_range(32, 65536)) : pools[ph]);
      no_gaps = (ph == 3);
      for (int i = 0; i < 210; i++) random_item();
    end
    no_gaps = 0;

    wait (outstanding == 0);
    repeat (40) @(posedge clk);
    $display("covered %0d allocates (%0d failed), %0d frees, %0d pool writes",
             n_alloc, n_fail, n_free, n_cfg + 1);
    if (mismatches == 0 && outstanding == 0) begin
      $display("first_fit_block_allocator_unit_test: clean");
    end else begin
      $display("first_fit_block_allocator_unit_test: errors");
    end
    $finish;
  end
endmodule
